// File: rtl/ssi_pkg.sv
// shared types and defaults for the segment crossing pipeline
// no dependencies
package ssi_pkg;

  localparam int COORD_WIDTH_DEF = 32;

  typedef enum logic [1:0] {
    ST_CROSS    = 2'd0,
    ST_PARALLEL = 2'd1,
    ST_OUT_B    = 2'd2,
    ST_OUT_A    = 2'd3
  } status_t;

endpackage

// File: rtl/segment_segment_intersection.sv
// Segment crossing test: each transfer carries two segments a and b as signed fixed-point
// endpoints; one result per transfer gives hit, the crossing point (zero on a miss) and a
// status code. One pair is taken every cycle unless the pipe holds. The pipe has seven stages
// of differences, products, cross products, sign fixup, range checks, the split point product
// and the numerator sum, then one stage per quotient bit of the two restoring dividers, then
// the output register. The whole pipe holds while a result waits.
// depends on ssi_pkg
module segment_segment_intersection #(
  parameter int COORD_WIDTH = ssi_pkg::COORD_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [COORD_WIDTH-1:0]  a_start_x,
  input  logic signed [COORD_WIDTH-1:0]  a_start_y,
  input  logic signed [COORD_WIDTH-1:0]  a_end_x,
  input  logic signed [COORD_WIDTH-1:0]  a_end_y,
  input  logic signed [COORD_WIDTH-1:0]  b_start_x,
  input  logic signed [COORD_WIDTH-1:0]  b_start_y,
  input  logic signed [COORD_WIDTH-1:0]  b_end_x,
  input  logic signed [COORD_WIDTH-1:0]  b_end_y,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           hit,
  output logic signed [COORD_WIDTH-1:0]  cross_x,
  output logic signed [COORD_WIDTH-1:0]  cross_y,
  output logic [1:0]                     status
);
  import ssi_pkg::*;

  localparam int W  = COORD_WIDTH;
  localparam int HW = W + 1;
  localparam int DM = 2 * HW;
  localparam int DW = DM + 1;
  localparam int NW = 3 * HW;

  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // stage 1: differences
  logic                 v1;
  logic signed [HW-1:0] s1x, s1y, s2x, s2y, dx, dy;
  logic signed [W-1:0]  p0x1, p0y1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
    if (en) begin
      s1x  <= $signed({a_end_x[W-1], a_end_x}) - $signed({a_start_x[W-1], a_start_x});
      s1y  <= $signed({a_end_y[W-1], a_end_y}) - $signed({a_start_y[W-1], a_start_y});
      s2x  <= $signed({b_end_x[W-1], b_end_x}) - $signed({b_start_x[W-1], b_start_x});
      s2y  <= $signed({b_end_y[W-1], b_end_y}) - $signed({b_start_y[W-1], b_start_y});
      dx   <= $signed({a_start_x[W-1], a_start_x}) - $signed({b_start_x[W-1], b_start_x});
      dy   <= $signed({a_start_y[W-1], a_start_y}) - $signed({b_start_y[W-1], b_start_y});
      p0x1 <= a_start_x;
      p0y1 <= a_start_y;
    end
  end

  // stage 2: six products
  logic                 v2;
  logic signed [DM-1:0] m_d0, m_d1, m_s0, m_s1, m_t0, m_t1;
  logic signed [HW-1:0] s1x2, s1y2;
  logic signed [W-1:0]  p0x2, p0y2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
    if (en) begin
      m_d0 <= s1x * s2y;
      m_d1 <= s2x * s1y;
      m_s0 <= s1x * dy;
      m_s1 <= s1y * dx;
      m_t0 <= s2x * dy;
      m_t1 <= s2y * dx;
      s1x2 <= s1x;
      s1y2 <= s1y;
      p0x2 <= p0x1;
      p0y2 <= p0y1;
    end
  end

  // stage 3: cross product and both numerators
  logic                 v3;
  logic signed [DW-1:0] d3, sn3, tn3;
  logic signed [HW-1:0] s1x3, s1y3;
  logic signed [W-1:0]  p0x3, p0y3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
    if (en) begin
      d3   <= $signed({m_d0[DM-1], m_d0}) - $signed({m_d1[DM-1], m_d1});
      sn3  <= $signed({m_s0[DM-1], m_s0}) - $signed({m_s1[DM-1], m_s1});
      tn3  <= $signed({m_t0[DM-1], m_t0}) - $signed({m_t1[DM-1], m_t1});
      s1x3 <= s1x2;
      s1y3 <= s1y2;
      p0x3 <= p0x2;
      p0y3 <= p0y2;
    end
  end

  // stage 4: make the denominator positive
  logic                 v4, dz4;
  logic signed [DW-1:0] d4, sn4, tn4;
  logic signed [HW-1:0] s1x4, s1y4;
  logic signed [W-1:0]  p0x4, p0y4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v3;
    end
    if (en) begin
      dz4  <= (d3 == '0);
      d4   <= d3[DW-1]  ? -d3  : d3;
      sn4  <= d3[DW-1]  ? -sn3 : sn3;
      tn4  <= d3[DW-1]  ? -tn3 : tn3;
      s1x4 <= s1x3;
      s1y4 <= s1y3;
      p0x4 <= p0x3;
      p0y4 <= p0y3;
    end
  end

  // stage 5: range checks, b first
  logic          v5, hit5;
  status_t       st5, st_c;
  logic [DM-1:0] d5, tn5;
  logic [HW-1:0] magx5, magy5;
  logic          negx5, negy5;
  logic signed [W-1:0] p0x5, p0y5;

  always_comb begin
    if (dz4) begin
      st_c = ST_PARALLEL;
    end else if (sn4[DW-1] || (sn4 > d4)) begin
      st_c = ST_OUT_B;
    end else if (tn4[DW-1] || (tn4 > d4)) begin
      st_c = ST_OUT_A;
    end else begin
      st_c = ST_CROSS;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en) begin
      v5 <= v4;
    end
    if (en) begin
      st5   <= st_c;
      hit5  <= (st_c == ST_CROSS);
      d5    <= d4[DM-1:0];
      tn5   <= tn4[DM-1:0];
      magx5 <= s1x4[HW-1] ? HW'(-s1x4) : HW'(s1x4);
      magy5 <= s1y4[HW-1] ? HW'(-s1y4) : HW'(s1y4);
      negx5 <= s1x4[HW-1];
      negy5 <= s1y4[HW-1];
      p0x5  <= p0x4;
      p0y5  <= p0y4;
    end
  end

  // stage 6: point numerator as two partial products per axis
  logic          v6, hit6, negx6, negy6;
  status_t       st6;
  logic [DM-1:0] d6, plx, phx, ply, phy;
  logic signed [W-1:0] p0x6, p0y6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (en) begin
      v6 <= v5;
    end
    if (en) begin
      plx   <= DM'(tn5[HW-1:0])  * DM'(magx5);
      phx   <= DM'(tn5[DM-1:HW]) * DM'(magx5);
      ply   <= DM'(tn5[HW-1:0])  * DM'(magy5);
      phy   <= DM'(tn5[DM-1:HW]) * DM'(magy5);
      st6   <= st5;
      hit6  <= hit5;
      d6    <= d5;
      negx6 <= negx5;
      negy6 <= negy5;
      p0x6  <= p0x5;
      p0y6  <= p0y5;
    end
  end

  // stage 7 and divider: one quotient bit per stage, index 0 is the summed numerator
  logic          dv    [0:HW];
  logic          dhit  [0:HW];
  status_t       dst   [0:HW];
  logic [DM-1:0] dden  [0:HW];
  logic [DM-1:0] remx  [0:HW];
  logic [DM-1:0] remy  [0:HW];
  logic [HW-1:0] lowx  [0:HW];
  logic [HW-1:0] lowy  [0:HW];
  logic [HW-1:0] qx    [0:HW];
  logic [HW-1:0] qy    [0:HW];
  logic          dnegx [0:HW];
  logic          dnegy [0:HW];
  logic signed [W-1:0] dbx [0:HW];
  logic signed [W-1:0] dby [0:HW];

  logic [NW-1:0] nx7, ny7;
  assign nx7 = {phx, {HW{1'b0}}} + NW'(plx);
  assign ny7 = {phy, {HW{1'b0}}} + NW'(ply);

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else if (en) begin
      dv[0] <= v6;
    end
    if (en) begin
      dhit[0]  <= hit6;
      dst[0]   <= st6;
      dden[0]  <= d6;
      remx[0]  <= nx7[NW-1:HW];
      remy[0]  <= ny7[NW-1:HW];
      lowx[0]  <= nx7[HW-1:0];
      lowy[0]  <= ny7[HW-1:0];
      qx[0]    <= '0;
      qy[0]    <= '0;
      dnegx[0] <= negx6;
      dnegy[0] <= negy6;
      dbx[0]   <= p0x6;
      dby[0]   <= p0y6;
    end
  end

  for (genvar k = 0; k < HW; k++) begin : g_div
    logic [DM:0] rx, ry, tx, ty;
    logic        gex, gey;

    assign rx  = {remx[k], lowx[k][HW-1]};
    assign ry  = {remy[k], lowy[k][HW-1]};
    assign tx  = rx - {1'b0, dden[k]};
    assign ty  = ry - {1'b0, dden[k]};
    assign gex = (rx >= {1'b0, dden[k]});
    assign gey = (ry >= {1'b0, dden[k]});

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[k+1] <= 1'b0;
      end else if (en) begin
        dv[k+1] <= dv[k];
      end
      if (en) begin
        remx[k+1]  <= gex ? tx[DM-1:0] : rx[DM-1:0];
        remy[k+1]  <= gey ? ty[DM-1:0] : ry[DM-1:0];
        lowx[k+1]  <= {lowx[k][HW-2:0], 1'b0};
        lowy[k+1]  <= {lowy[k][HW-2:0], 1'b0};
        qx[k+1]    <= {qx[k][HW-2:0], gex};
        qy[k+1]    <= {qy[k][HW-2:0], gey};
        dhit[k+1]  <= dhit[k];
        dst[k+1]   <= dst[k];
        dden[k+1]  <= dden[k];
        dnegx[k+1] <= dnegx[k];
        dnegy[k+1] <= dnegy[k];
        dbx[k+1]   <= dbx[k];
        dby[k+1]   <= dby[k];
      end
    end
  end

  // output register: signed offset added to the first segment start
  logic [W-1:0] offx, offy;
  assign offx = dnegx[HW] ? W'(-qx[HW]) : qx[HW][W-1:0];
  assign offy = dnegy[HW] ? W'(-qy[HW]) : qy[HW][W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dv[HW];
    end
    if (en) begin
      hit     <= dhit[HW];
      status  <= dst[HW];
      cross_x <= dhit[HW] ? $signed(dbx[HW] + offx) : '0;
      cross_y <= dhit[HW] ? $signed(dby[HW] + offy) : '0;
    end
  end

  a_hit_status : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (hit == (status == ST_CROSS)))
    else $error("hit and status disagree");

  a_miss_zero : assert property (@(posedge clk) disable iff (rst)
    (out_valid && !hit) |-> (cross_x == '0 && cross_y == '0))
    else $error("point not zero on a miss");

  a_hold : assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(cross_x) && $stable(status)))
    else $error("waiting result changed");

  a_backpressure : assert property (@(posedge clk) disable iff (rst)
    in_stall == (out_valid && out_stall))
    else $error("input stall does not follow output");

endmodule
